// ===== rtl/core/ldpm_pkg.sv =====
// Package for the lens distortion point map: register codes, saturation type
// and the fixed-point helper functions used by the datapath.
// No dependencies.
`timescale 1ns / 1ps

package ldpm_pkg;

	// Fraction bits of the normalized format (Q8.24)
	localparam int QFrac = 24;
	// Quotient bits produced by the normalizing divider
	localparam int DivSteps = 32;

	// Register index codes (paddr[5:3])
	typedef enum logic [2:0] {
		REG_FOCAL_X    = 3'd0,
		REG_FOCAL_Y    = 3'd1,
		REG_CENTER_X   = 3'd2,
		REG_CENTER_Y   = 3'd3,
		REG_RADIAL_K1  = 3'd4,
		REG_RADIAL_K2  = 3'd5,
		REG_RADIAL_K3  = 3'd6,
		REG_TANGENTIAL = 3'd7
	} reg_idx_t;

	// Saturated 32-bit value with its clamp flag
	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	// Sideband that rides along the divider stages
	typedef struct packed {
		logic               byp;
		logic               neg_x;
		logic               neg_y;
		logic               ovf_x;
		logic               ovf_y;
		logic signed [31:0] ix;
		logic signed [31:0] iy;
	} div_sb_t;

	// Clamp a wide signed value to signed 32 bits
	function automatic sat_t sat32(input logic signed [65:0] v);
		sat_t r;
		if (v > 66'sd2147483647) begin
			r.ovf = 1'b1;
			r.val = 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			r.ovf = 1'b1;
			r.val = 32'sh80000000;
		end else begin
			r.ovf = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

	// Full signed 32x32 product
	function automatic logic signed [63:0] smul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return 64'(a) * 64'(b);
	endfunction

	// Q8.24 product rescale: round half up, then clamp
	function automatic sat_t qround(input logic signed [63:0] p);
		logic signed [65:0] t;
		t = 66'(p) + 66'sd8388608;
		return sat32(t >>> QFrac);
	endfunction

endpackage

// ===== rtl/core/lens_distortion_point_map.sv =====
// Lens distortion point map, top level: APB register file and the full
// radial/tangential pipeline (normalize divider, polynomial, back to pixels).
// Depends on ldpm_pkg.
`timescale 1ns / 1ps
// Pipeline: 47 register stages from the input word to out_valid.
// Throughput: one word per cycle unless the output stalls; the 32-stage restoring
// divider and the multiplier chain are fully pipelined, so a word enters every clock.
// A stall while out_valid is high freezes the whole pipeline in place.
// Reset: asynchronous, active low; clears all valid bits, focal lengths
// come up at 65536 and all other configuration registers at zero.

module lens_distortion_point_map (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] ideal_x,
	input  logic signed [31:0] ideal_y,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] distorted_x,
	output logic signed [31:0] distorted_y,
	output logic               range_flag
);
	import ldpm_pkg::*;

	// ---------------- configuration registers ----------------
	logic [31:0]        focal_x_q, focal_y_q;
	logic signed [31:0] center_x_q, center_y_q;
	logic signed [31:0] k1_q, k2_q, k3_q;
	logic [63:0]        tang_q;
	reg_idx_t           cfg_idx;

	assign cfg_idx = reg_idx_t'(paddr[5:3]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= 32'd65536;
			focal_y_q  <= 32'd65536;
			center_x_q <= '0;
			center_y_q <= '0;
			k1_q       <= '0;
			k2_q       <= '0;
			k3_q       <= '0;
			tang_q     <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (cfg_idx)
				REG_FOCAL_X:    focal_x_q  <= pwdata[31:0];
				REG_FOCAL_Y:    focal_y_q  <= pwdata[31:0];
				REG_CENTER_X:   center_x_q <= pwdata[31:0];
				REG_CENTER_Y:   center_y_q <= pwdata[31:0];
				REG_RADIAL_K1:  k1_q       <= pwdata[31:0];
				REG_RADIAL_K2:  k2_q       <= pwdata[31:0];
				REG_RADIAL_K3:  k3_q       <= pwdata[31:0];
				REG_TANGENTIAL: tang_q     <= pwdata;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (cfg_idx)
			REG_FOCAL_X:    prdata = {32'd0, focal_x_q};
			REG_FOCAL_Y:    prdata = {32'd0, focal_y_q};
			REG_CENTER_X:   prdata = {32'd0, center_x_q};
			REG_CENTER_Y:   prdata = {32'd0, center_y_q};
			REG_RADIAL_K1:  prdata = {32'd0, k1_q};
			REG_RADIAL_K2:  prdata = {32'd0, k2_q};
			REG_RADIAL_K3:  prdata = {32'd0, k3_q};
			REG_TANGENTIAL: prdata = tang_q;
		endcase
	end

	// derived constants; the user must change config only while the pipe is empty (not enforced)
	logic [31:0]        fzx, fzy;
	logic signed [31:0] p0, p1;
	assign fzx = (focal_x_q == 32'd0) ? 32'd1 : focal_x_q;
	assign fzy = (focal_y_q == 32'd0) ? 32'd1 : focal_y_q;
	assign p0  = tang_q[63:32];
	assign p1  = tang_q[31:0];

	// global advance: whole pipe moves unless the output word is held
	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// ---------------- stage 1: center offset and magnitude ----------------
	logic               v_s1, byp_s1, negx_s1, negy_s1;
	logic signed [31:0] ix_s1, iy_s1;
	logic [31:0]        magx_s1, magy_s1;
	logic signed [32:0] dx, dy, adx, ady;

	always_comb begin
		dx  = 33'(ideal_x) - 33'(center_x_q);
		dy  = 33'(ideal_y) - 33'(center_y_q);
		adx = dx[32] ? -dx : dx;
		ady = dy[32] ? -dy : dy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s1  <= (k1_q == 32'sd0);
			ix_s1   <= ideal_x;
			iy_s1   <= ideal_y;
			negx_s1 <= dx[32];
			negy_s1 <= dy[32];
			magx_s1 <= adx[31:0];
			magy_s1 <= ady[31:0];
		end
	end

	// ---------------- stage 2: dividend, overflow check ----------------
	logic [31:0] rx_sd [0:DivSteps];
	logic [31:0] ry_sd [0:DivSteps];
	logic [31:0] nbx_sd [0:DivSteps];
	logic [31:0] nby_sd [0:DivSteps];
	logic [31:0] qx_sd [0:DivSteps];
	logic [31:0] qy_sd [0:DivSteps];
	div_sb_t     sb_sd [0:DivSteps];
	logic        v_sd [0:DivSteps];
	logic [56:0] nx, ny;

	// rounded dividend: (mag << 24) + fz/2
	always_comb begin
		nx = {1'b0, magx_s1, 24'd0} + 57'(fzx >> 1);
		ny = {1'b0, magy_s1, 24'd0} + 57'(fzy >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_sd[0]        <= 32'(nx[56:32]);
			ry_sd[0]        <= 32'(ny[56:32]);
			nbx_sd[0]       <= nx[31:0];
			nby_sd[0]       <= ny[31:0];
			qx_sd[0]        <= '0;
			qy_sd[0]        <= '0;
			sb_sd[0].byp    <= byp_s1;
			sb_sd[0].neg_x  <= negx_s1;
			sb_sd[0].neg_y  <= negy_s1;
			// quotient of 2^32 or more always clamps
			sb_sd[0].ovf_x  <= ({7'd0, nx[56:32]} >= fzx);
			sb_sd[0].ovf_y  <= ({7'd0, ny[56:32]} >= fzy);
			sb_sd[0].ix     <= ix_s1;
			sb_sd[0].iy     <= iy_s1;
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		logic [32:0] tx_w, ty_w, sx_w, sy_w;
		logic        gex, gey;

		always_comb begin
			tx_w = {rx_sd[k], nbx_sd[k][31]};
			ty_w = {ry_sd[k], nby_sd[k][31]};
			sx_w = tx_w - {1'b0, fzx};
			sy_w = ty_w - {1'b0, fzy};
			gex  = (tx_w >= {1'b0, fzx});
			gey  = (ty_w >= {1'b0, fzy});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_sd[k+1]  <= gex ? sx_w[31:0] : tx_w[31:0];
				ry_sd[k+1]  <= gey ? sy_w[31:0] : ty_w[31:0];
				nbx_sd[k+1] <= nbx_sd[k] << 1;
				nby_sd[k+1] <= nby_sd[k] << 1;
				qx_sd[k+1]  <= {qx_sd[k][30:0], gex};
				qy_sd[k+1]  <= {qy_sd[k][30:0], gey};
				sb_sd[k+1]  <= sb_sd[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (en) begin
				v_sd[k+1] <= v_sd[k];
			end
		end
	end

	// ---------------- stage 3: clamp and sign the quotients ----------------
	logic               v_s3, f_s3, byp_s3;
	logic signed [31:0] ix_s3, iy_s3, xn_s3, yn_s3;
	logic [31:0]        limx, limy, qqx, qqy;
	logic               satx, saty;
	div_sb_t            sbq;

	always_comb begin
		sbq  = sb_sd[DivSteps];
		limx = sbq.neg_x ? 32'h80000000 : 32'h7FFFFFFF;
		limy = sbq.neg_y ? 32'h80000000 : 32'h7FFFFFFF;
		satx = sbq.ovf_x || (qx_sd[DivSteps] > limx);
		saty = sbq.ovf_y || (qy_sd[DivSteps] > limy);
		qqx  = satx ? limx : qx_sd[DivSteps];
		qqy  = saty ? limy : qy_sd[DivSteps];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xn_s3  <= sbq.neg_x ? -qqx : qqx;
			yn_s3  <= sbq.neg_y ? -qqy : qqy;
			f_s3   <= satx || saty;
			byp_s3 <= sbq.byp;
			ix_s3  <= sbq.ix;
			iy_s3  <= sbq.iy;
		end
	end

	// ---------------- stage 4: squares and cross product ----------------
	logic               f_s4, byp_s4;
	logic signed [31:0] ix_s4, iy_s4, xn_s4, yn_s4;
	logic signed [63:0] pxx_s4, pyy_s4, pxy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s4 <= smul(xn_s3, xn_s3);
			pyy_s4 <= smul(yn_s3, yn_s3);
			pxy_s4 <= smul(xn_s3, yn_s3);
			xn_s4  <= xn_s3;
			yn_s4  <= yn_s3;
			f_s4   <= f_s3;
			byp_s4 <= byp_s3;
			ix_s4  <= ix_s3;
			iy_s4  <= iy_s3;
		end
	end

	// ---------------- stage 5: r2 and tangential sums ----------------
	logic               f_s5, byp_s5;
	logic signed [31:0] ix_s5, iy_s5, xn_s5, yn_s5;
	logic signed [31:0] r2_s5, xy_s5, ux_s5, uy_s5;
	sat_t               x2_w, y2_w, xy_w, r2_w, ux_w, uy_w;

	always_comb begin
		x2_w = qround(pxx_s4);
		y2_w = qround(pyy_s4);
		xy_w = qround(pxy_s4);
		r2_w = sat32(66'(x2_w.val) + 66'(y2_w.val));
		ux_w = sat32(66'(r2_w.val) + (66'(x2_w.val) <<< 1));
		uy_w = sat32(66'(r2_w.val) + (66'(y2_w.val) <<< 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s5  <= r2_w.val;
			xy_s5  <= xy_w.val;
			ux_s5  <= ux_w.val;
			uy_s5  <= uy_w.val;
			f_s5   <= f_s4 || x2_w.ovf || y2_w.ovf || xy_w.ovf || r2_w.ovf
				|| ux_w.ovf || uy_w.ovf;
			xn_s5  <= xn_s4;
			yn_s5  <= yn_s4;
			byp_s5 <= byp_s4;
			ix_s5  <= ix_s4;
			iy_s5  <= iy_s4;
		end
	end

	// ---------------- stage 6: r4, k1 and tangential products ----------------
	logic               f_s6, byp_s6;
	logic signed [31:0] ix_s6, iy_s6, xn_s6, yn_s6, r2_s6;
	logic signed [63:0] prr_s6, pk1_s6, ptx0_s6, ptx1_s6, pty0_s6, pty1_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			prr_s6  <= smul(r2_s5, r2_s5);
			pk1_s6  <= smul(k1_q, r2_s5);
			ptx0_s6 <= smul(p0, ux_s5);
			ptx1_s6 <= smul(p1, xy_s5);
			pty0_s6 <= smul(p1, uy_s5);
			pty1_s6 <= smul(p0, xy_s5);
			r2_s6   <= r2_s5;
			xn_s6   <= xn_s5;
			yn_s6   <= yn_s5;
			f_s6    <= f_s5;
			byp_s6  <= byp_s5;
			ix_s6   <= ix_s5;
			iy_s6   <= iy_s5;
		end
	end

	// ---------------- stage 7: r4, k1 term, tangential offsets ----------------
	logic               f_s7, byp_s7;
	logic signed [31:0] ix_s7, iy_s7, xn_s7, yn_s7, r2_s7;
	logic signed [31:0] r4_s7, kr1_s7, tx_s7, ty_s7;
	sat_t               r4_w, kr1_w, tx0_w, tx1_w, ty0_w, ty1_w, txs_w, tys_w;

	always_comb begin
		r4_w  = qround(prr_s6);
		kr1_w = qround(pk1_s6);
		tx0_w = qround(ptx0_s6);
		tx1_w = qround(ptx1_s6);
		ty0_w = qround(pty0_s6);
		ty1_w = qround(pty1_s6);
		txs_w = sat32(66'(tx0_w.val) + (66'(tx1_w.val) <<< 1));
		tys_w = sat32(66'(ty0_w.val) + (66'(ty1_w.val) <<< 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r4_s7  <= r4_w.val;
			kr1_s7 <= kr1_w.val;
			tx_s7  <= txs_w.val;
			ty_s7  <= tys_w.val;
			f_s7   <= f_s6 || r4_w.ovf || kr1_w.ovf || tx0_w.ovf || tx1_w.ovf
				|| ty0_w.ovf || ty1_w.ovf || txs_w.ovf || tys_w.ovf;
			r2_s7  <= r2_s6;
			xn_s7  <= xn_s6;
			yn_s7  <= yn_s6;
			byp_s7 <= byp_s6;
			ix_s7  <= ix_s6;
			iy_s7  <= iy_s6;
		end
	end

	// ---------------- stage 8: r6 and k2 products ----------------
	logic               f_s8, byp_s8;
	logic signed [31:0] ix_s8, iy_s8, xn_s8, yn_s8, kr1_s8, tx_s8, ty_s8;
	logic signed [63:0] pr6_s8, pk2_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			pr6_s8 <= smul(r2_s7, r4_s7);
			pk2_s8 <= smul(k2_q, r4_s7);
			kr1_s8 <= kr1_s7;
			tx_s8  <= tx_s7;
			ty_s8  <= ty_s7;
			xn_s8  <= xn_s7;
			yn_s8  <= yn_s7;
			f_s8   <= f_s7;
			byp_s8 <= byp_s7;
			ix_s8  <= ix_s7;
			iy_s8  <= iy_s7;
		end
	end

	// ---------------- stage 9: r6 and k2 term ----------------
	logic               f_s9, byp_s9;
	logic signed [31:0] ix_s9, iy_s9, xn_s9, yn_s9, kr1_s9, tx_s9, ty_s9;
	logic signed [31:0] r6_s9, kr2_s9;
	sat_t               r6_w, kr2_w;

	always_comb begin
		r6_w  = qround(pr6_s8);
		kr2_w = qround(pk2_s8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r6_s9  <= r6_w.val;
			kr2_s9 <= kr2_w.val;
			f_s9   <= f_s8 || r6_w.ovf || kr2_w.ovf;
			kr1_s9 <= kr1_s8;
			tx_s9  <= tx_s8;
			ty_s9  <= ty_s8;
			xn_s9  <= xn_s8;
			yn_s9  <= yn_s8;
			byp_s9 <= byp_s8;
			ix_s9  <= ix_s8;
			iy_s9  <= iy_s8;
		end
	end

	// ---------------- stage 10: k3 product ----------------
	logic               f_s10, byp_s10;
	logic signed [31:0] ix_s10, iy_s10, xn_s10, yn_s10, kr1_s10, kr2_s10;
	logic signed [31:0] tx_s10, ty_s10;
	logic signed [63:0] pk3_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			pk3_s10 <= smul(k3_q, r6_s9);
			kr1_s10 <= kr1_s9;
			kr2_s10 <= kr2_s9;
			tx_s10  <= tx_s9;
			ty_s10  <= ty_s9;
			xn_s10  <= xn_s9;
			yn_s10  <= yn_s9;
			f_s10   <= f_s9;
			byp_s10 <= byp_s9;
			ix_s10  <= ix_s9;
			iy_s10  <= iy_s9;
		end
	end

	// ---------------- stage 11: radial factor ----------------
	logic               f_s11, byp_s11;
	logic signed [31:0] ix_s11, iy_s11, xn_s11, yn_s11, tx_s11, ty_s11, rad_s11;
	sat_t               kr3_w, rad_w;

	always_comb begin
		kr3_w = qround(pk3_s10);
		rad_w = sat32((66'sd1 <<< QFrac) + 66'(kr1_s10) + 66'(kr2_s10)
			+ 66'(kr3_w.val));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s11 <= rad_w.val;
			f_s11   <= f_s10 || kr3_w.ovf || rad_w.ovf;
			tx_s11  <= tx_s10;
			ty_s11  <= ty_s10;
			xn_s11  <= xn_s10;
			yn_s11  <= yn_s10;
			byp_s11 <= byp_s10;
			ix_s11  <= ix_s10;
			iy_s11  <= iy_s10;
		end
	end

	// ---------------- stage 12: radial scaling products ----------------
	logic               f_s12, byp_s12;
	logic signed [31:0] ix_s12, iy_s12, tx_s12, ty_s12;
	logic signed [63:0] prx_s12, pry_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			prx_s12 <= smul(rad_s11, xn_s11);
			pry_s12 <= smul(rad_s11, yn_s11);
			tx_s12  <= tx_s11;
			ty_s12  <= ty_s11;
			f_s12   <= f_s11;
			byp_s12 <= byp_s11;
			ix_s12  <= ix_s11;
			iy_s12  <= iy_s11;
		end
	end

	// ---------------- stage 13: distorted normalized point ----------------
	logic               f_s13, byp_s13;
	logic signed [31:0] ix_s13, iy_s13, xd_s13, yd_s13;
	sat_t               rx_w, ry_w, xd_w, yd_w;

	always_comb begin
		rx_w = qround(prx_s12);
		ry_w = qround(pry_s12);
		xd_w = sat32(66'(rx_w.val) + 66'(tx_s12));
		yd_w = sat32(66'(ry_w.val) + 66'(ty_s12));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xd_s13  <= xd_w.val;
			yd_s13  <= yd_w.val;
			f_s13   <= f_s12 || rx_w.ovf || ry_w.ovf || xd_w.ovf || yd_w.ovf;
			byp_s13 <= byp_s12;
			ix_s13  <= ix_s12;
			iy_s13  <= iy_s12;
		end
	end

	// ---------------- stage 14: scale back by focal length ----------------
	logic               f_s14, byp_s14, negx_s14, negy_s14;
	logic signed [31:0] ix_s14, iy_s14;
	logic [63:0]        pfx_s14, pfy_s14;
	logic signed [32:0] mx_w, my_w;

	always_comb begin
		mx_w = xd_s13[31] ? -33'(xd_s13) : 33'(xd_s13);
		my_w = yd_s13[31] ? -33'(yd_s13) : 33'(yd_s13);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pfx_s14  <= 64'(mx_w[31:0]) * 64'(fzx);
			pfy_s14  <= 64'(my_w[31:0]) * 64'(fzy);
			negx_s14 <= xd_s13[31];
			negy_s14 <= yd_s13[31];
			f_s14    <= f_s13;
			byp_s14  <= byp_s13;
			ix_s14   <= ix_s13;
			iy_s14   <= iy_s13;
		end
	end

	// ---------------- stage 15: round, add center, output word ----------------
	logic               v_s15, byp_s15;
	logic signed [31:0] ox_s15, oy_s15;
	logic               f_s15;
	logic [64:0]        rpx, rpy;
	logic signed [65:0] sx_w, sy_w;
	sat_t               ox_w, oy_w;

	always_comb begin
		rpx  = (65'(pfx_s14) + 65'd8388608) >> QFrac;
		rpy  = (65'(pfy_s14) + 65'd8388608) >> QFrac;
		sx_w = negx_s14 ? -66'(rpx[40:0]) : 66'(rpx[40:0]);
		sy_w = negy_s14 ? -66'(rpy[40:0]) : 66'(rpy[40:0]);
		ox_w = sat32(sx_w + 66'(center_x_q));
		oy_w = sat32(sy_w + 66'(center_y_q));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s15  <= byp_s14 ? ix_s14 : ox_w.val;
			oy_s15  <= byp_s14 ? iy_s14 : oy_w.val;
			f_s15   <= !byp_s14 && (f_s14 || ox_w.ovf || oy_w.ovf);
			byp_s15 <= byp_s14;
		end
	end

	assign out_valid   = v_s15;
	assign distorted_x = ox_s15;
	assign distorted_y = oy_s15;
	assign range_flag  = f_s15;

	// ---------------- valid bits ----------------
	logic v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_sd[0]  <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
			v_s10    <= 1'b0;
			v_s11    <= 1'b0;
			v_s12    <= 1'b0;
			v_s13    <= 1'b0;
			v_s14    <= 1'b0;
			v_s15    <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			v_sd[0]  <= v_s1;
			v_s3     <= v_sd[DivSteps];
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			v_s8     <= v_s7;
			v_s9     <= v_s8;
			v_s10    <= v_s9;
			v_s11    <= v_s10;
			v_s12    <= v_s11;
			v_s13    <= v_s12;
			v_s14    <= v_s13;
			v_s15    <= v_s14;
		end
	end

	// ---------------- assertions ----------------
	// divider remainder stays below the divisor when no early overflow
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_sd[DivSteps] && !sb_sd[DivSteps].ovf_x |-> rx_sd[DivSteps] < fzx)
		else $error("x divider remainder out of range");

	a_div_rem_y: assert property (@(posedge clk) disable iff (!arst_n)
		v_sd[DivSteps] && !sb_sd[DivSteps].ovf_y |-> ry_sd[DivSteps] < fzy)
		else $error("y divider remainder out of range");

	// a bypassed point never reports a clamp
	a_byp_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byp_s15 |-> !range_flag)
		else $error("range flag set on bypassed word");

	// an accepted word lands in the first stage
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted word lost at pipeline entry");

	// a held output word keeps its flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(range_flag))
		else $error("stalled output word changed");

endmodule
